// ===== sv/bta_pkg.sv =====
// Package for the boundary-tag allocator: pool geometry, micro-operation codes,
// result codes and the command and status structs between controller and datapath.
// No dependencies.
package bta_pkg;

	localparam int MEM_WORDS = 64;
	localparam int AW = $clog2(MEM_WORDS);
	localparam int SW = AW + 1;

	typedef logic [AW-1:0] addr_t;
	typedef logic [SW-1:0] size_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOFIT   = 2'd1,
		ST_BADFREE = 2'd2
	} st_t;

	typedef enum logic [5:0] {
		UOP_NOP, UOP_LOAD, UOP_CLR,
		UOP_A_START, UOP_A_RD, UOP_A_CHK,
		UOP_W1, UOP_W2, UOP_W3, UOP_W4,
		UOP_S1, UOP_S2, UOP_S3, UOP_S4,
		UOP_F_START, UOP_F_WRD, UOP_F_WCHK, UOP_F_TRD, UOP_F_TCHK,
		UOP_F_URD, UOP_F_UCHK, UOP_F_PRD, UOP_F_PCHK, UOP_F_NRD, UOP_F_NCHK,
		UOP_L1, UOP_L2, UOP_L3E, UOP_L3, UOP_L4, UOP_L5, UOP_L6,
		UOP_R1, UOP_M1, UOP_M2, UOP_M3, UOP_B1, UOP_B2,
		UOP_DONE
	} uop_t;

	typedef struct packed {
		uop_t uop;
		st_t  code;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic a_bad;
		logic fit;
		logic whole;
		logic wrap;
		logic single;
		logic w_ge;
		logic w_eq;
		logic zero_sz;
		logic hdr_used;
		logic a_zero;
		logic nx_out;
		logic lused;
		logic rused;
		logic empty;
		logic m_self;
		logic out_busy;
	} sts_t;

	// Map an out-of-range word index to word 0.
	function automatic addr_t ix(input size_t v);
		ix = (v < size_t'(MEM_WORDS)) ? v[AW-1:0] : '0;
	endfunction

	// Last word of a block that starts at p and holds s words.
	function automatic addr_t foot(input addr_t p, input size_t s);
		size_t t;
		t = size_t'(p) + ((s != '0) ? (s - size_t'(1)) : '0);
		foot = ix(t);
	endfunction

endpackage

// ===== sv/bta_ctrl.sv =====
// Boundary-tag allocator controller: one-hot sequencer for clear, allocate and free.
// Depends on bta_pkg; drives bta_dp through cmd_t and reads sts_t.
module bta_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  logic          req_type,
	input  bta_pkg::sts_t sts,
	output logic          s_tready,
	output bta_pkg::cmd_t cmd
);
	import bta_pkg::*;

	typedef enum logic [38:0] {
		S_IDLE    = 39'd1 << 0,  S_CLR     = 39'd1 << 1,  S_A_START = 39'd1 << 2,
		S_A_RD    = 39'd1 << 3,  S_A_CHK   = 39'd1 << 4,  S_W1      = 39'd1 << 5,
		S_W2      = 39'd1 << 6,  S_W3      = 39'd1 << 7,  S_W4      = 39'd1 << 8,
		S_S1      = 39'd1 << 9,  S_S2      = 39'd1 << 10, S_S3      = 39'd1 << 11,
		S_S4      = 39'd1 << 12, S_F_START = 39'd1 << 13, S_F_WRD   = 39'd1 << 14,
		S_F_WCHK  = 39'd1 << 15, S_F_TRD   = 39'd1 << 16, S_F_TCHK  = 39'd1 << 17,
		S_F_URD   = 39'd1 << 18, S_F_UCHK  = 39'd1 << 19, S_F_PRD   = 39'd1 << 20,
		S_F_PCHK  = 39'd1 << 21, S_F_NRD   = 39'd1 << 22, S_F_NCHK  = 39'd1 << 23,
		S_F_DISP  = 39'd1 << 24, S_L1      = 39'd1 << 25, S_L2      = 39'd1 << 26,
		S_L3E     = 39'd1 << 27, S_L3      = 39'd1 << 28, S_L4      = 39'd1 << 29,
		S_L5      = 39'd1 << 30, S_L6      = 39'd1 << 31, S_R1      = 39'd1 << 32,
		S_M1      = 39'd1 << 33, S_M2      = 39'd1 << 34, S_M3      = 39'd1 << 35,
		S_B1      = 39'd1 << 36, S_B2      = 39'd1 << 37, S_DONE    = 39'd1 << 38
	} state_t;

	state_t state_q, state_d;
	st_t    code_q, code_d;
	uop_t   uop;

	assign s_tready = (state_q == S_IDLE);
	assign cmd      = '{uop: uop, code: code_q};

	always_comb begin
		state_d = state_q;
		code_d  = code_q;
		uop     = UOP_NOP;
		unique case (state_q)
			S_CLR: begin
				uop = UOP_CLR;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (s_tvalid) begin
					uop     = UOP_LOAD;
					code_d  = ST_OK;
					state_d = req_type ? S_F_START : S_A_START;
				end
			end
			S_A_START: begin
				uop = UOP_A_START;
				if (sts.a_bad) begin
					code_d  = ST_NOFIT;
					state_d = S_DONE;
				end else begin
					state_d = S_A_RD;
				end
			end
			S_A_RD: begin
				uop     = UOP_A_RD;
				state_d = S_A_CHK;
			end
			S_A_CHK: begin
				uop = UOP_A_CHK;
				if (sts.fit) state_d = sts.whole ? S_W1 : S_S1;
				else if (sts.wrap) begin
					code_d  = ST_NOFIT;
					state_d = S_DONE;
				end else state_d = S_A_RD;
			end
			S_W1: begin
				uop     = UOP_W1;
				state_d = sts.single ? S_W3 : S_W2;
			end
			S_W2: begin uop = UOP_W2; state_d = S_W3; end
			S_W3: begin uop = UOP_W3; state_d = S_W4; end
			S_W4: begin uop = UOP_W4; state_d = S_DONE; end
			S_S1: begin uop = UOP_S1; state_d = S_S2; end
			S_S2: begin uop = UOP_S2; state_d = S_S3; end
			S_S3: begin uop = UOP_S3; state_d = S_S4; end
			S_S4: begin uop = UOP_S4; state_d = S_DONE; end
			S_F_START: begin uop = UOP_F_START; state_d = S_F_WRD; end
			S_F_WRD: begin
				uop = UOP_F_WRD;
				if (sts.w_ge) begin
					if (sts.w_eq) state_d = S_F_TRD;
					else begin
						code_d  = ST_BADFREE;
						state_d = S_DONE;
					end
				end else state_d = S_F_WCHK;
			end
			S_F_WCHK: begin
				uop = UOP_F_WCHK;
				if (sts.zero_sz) begin
					code_d  = ST_BADFREE;
					state_d = S_DONE;
				end else state_d = S_F_WRD;
			end
			S_F_TRD: begin uop = UOP_F_TRD; state_d = S_F_TCHK; end
			S_F_TCHK: begin
				uop = UOP_F_TCHK;
				if (!sts.hdr_used) begin
					code_d  = ST_BADFREE;
					state_d = S_DONE;
				end else state_d = sts.a_zero ? S_F_NRD : S_F_URD;
			end
			S_F_URD:  begin uop = UOP_F_URD;  state_d = S_F_UCHK; end
			S_F_UCHK: begin uop = UOP_F_UCHK; state_d = S_F_PRD;  end
			S_F_PRD:  begin uop = UOP_F_PRD;  state_d = S_F_PCHK; end
			S_F_PCHK: begin uop = UOP_F_PCHK; state_d = S_F_NRD;  end
			S_F_NRD: begin
				uop     = UOP_F_NRD;
				state_d = sts.nx_out ? S_F_DISP : S_F_NCHK;
			end
			S_F_NCHK: begin uop = UOP_F_NCHK; state_d = S_F_DISP; end
			S_F_DISP: begin
				if (sts.lused && sts.rused) state_d = S_L1;
				else if (sts.rused) state_d = S_R1;
				else if (sts.lused) state_d = S_M1;
				else state_d = S_B1;
			end
			S_L1: begin uop = UOP_L1; state_d = S_L2; end
			S_L2: begin
				uop     = UOP_L2;
				state_d = sts.empty ? S_L3E : S_L3;
			end
			S_L3E: begin uop = UOP_L3E; state_d = S_DONE; end
			S_L3:  begin uop = UOP_L3;  state_d = S_L4;   end
			S_L4:  begin uop = UOP_L4;  state_d = S_L5;   end
			S_L5:  begin uop = UOP_L5;  state_d = S_L6;   end
			S_L6:  begin uop = UOP_L6;  state_d = S_DONE; end
			S_R1:  begin uop = UOP_R1;  state_d = S_DONE; end
			S_M1: begin
				uop     = UOP_M1;
				state_d = sts.m_self ? S_DONE : S_M2;
			end
			S_M2: begin uop = UOP_M2; state_d = S_M3;   end
			S_M3: begin uop = UOP_M3; state_d = S_DONE; end
			S_B1: begin uop = UOP_B1; state_d = S_B2;   end
			S_B2: begin uop = UOP_B2; state_d = S_DONE; end
			S_DONE: begin
				if (!sts.out_busy) begin
					uop     = UOP_DONE;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			code_q  <= ST_OK;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

endmodule

// ===== sv/bta_dp.sv =====
// Datapath of the boundary-tag allocator: the five word-field memories, the walk and
// merge registers, the rover, the configuration register and the result register.
// Depends on bta_pkg; commanded by bta_ctrl.
module bta_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  bta_pkg::cmd_t cmd,
	output bta_pkg::sts_t sts,
	input  logic [15:0]   s_tdata,
	input  logic          cfg_valid,
	input  logic [3:0]    cfg_data,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [15:0]   m_tdata,
	output logic [1:0]    m_tuser
);
	import bta_pkg::*;

	logic  mem_tag [MEM_WORDS];
	size_t mem_size [MEM_WORDS];
	addr_t mem_left [MEM_WORDS];
	addr_t mem_right [MEM_WORDS];
	addr_t mem_up [MEM_WORDS];

	logic  rd_tag;
	size_t rd_size;
	addr_t rd_left, rd_right, rd_up, rd_addr;

	logic  we_tag, we_size, we_left, we_right, we_up;
	addr_t wa_tag, wa_size, wa_left, wa_right, wa_up;
	logic  wd_tag;
	size_t wd_size;
	addr_t wd_left, wd_right, wd_up;

	addr_t p_q, a_q, lp_q, rp_q, f_q, q_q, pre_q, ql_q, rr_q, q2_q, fn_q, clr_q;
	addr_t rover_q, res_addr_q, out_addr_q;
	size_t n_q, w_q, sp_q, sa_q, nx_q, spre_q, snx_q, res_size_q, out_size_q;
	logic  lused_q, rused_q, empty_q, out_valid_q;
	logic [3:0] minrem_q;
	st_t   out_st_q;

	size_t diff, f7;
	addr_t fa, rover_nx;

	assign diff = sp_q - n_q;
	assign f7   = size_t'(p_q) + diff - size_t'(1);
	assign fa   = foot(a_q, sa_q);
	// Rover follows a free block that a merge swallows.
	assign rover_nx = (size_t'(rover_q) == nx_q) ? ((cmd.uop == UOP_B1) ? pre_q : a_q) : rover_q;

	always_comb begin
		case (cmd.uop)
			UOP_A_RD:  rd_addr = p_q;
			UOP_F_WRD: rd_addr = w_q[AW-1:0];
			UOP_F_TRD: rd_addr = a_q;
			UOP_F_URD: rd_addr = a_q - addr_t'(1);
			UOP_F_PRD: rd_addr = pre_q;
			UOP_F_NRD: rd_addr = nx_q[AW-1:0];
			UOP_L3:    rd_addr = rover_q;
			default:   rd_addr = '0;
		endcase
	end

	always_comb begin
		we_tag = 1'b0; wa_tag = '0; wd_tag = 1'b0;
		we_size = 1'b0; wa_size = '0; wd_size = '0;
		we_left = 1'b0; wa_left = '0; wd_left = '0;
		we_right = 1'b0; wa_right = '0; wd_right = '0;
		we_up = 1'b0; wa_up = '0; wd_up = '0;
		case (cmd.uop)
			UOP_CLR: begin
				we_tag = 1'b1; wa_tag = clr_q;
				we_size = 1'b1; wa_size = clr_q;
				wd_size = (clr_q == '0) ? size_t'(MEM_WORDS) : '0;
				we_left = 1'b1; wa_left = clr_q;
				we_right = 1'b1; wa_right = clr_q;
				we_up = 1'b1; wa_up = clr_q;
			end
			UOP_W1: begin
				we_left = !sts.single; wa_left = rp_q; wd_left = lp_q;
			end
			UOP_W2: begin we_right = 1'b1; wa_right = lp_q; wd_right = rp_q; end
			UOP_W3: begin we_tag = 1'b1; wa_tag = p_q; wd_tag = 1'b1; end
			UOP_W4: begin
				we_tag = 1'b1; wa_tag = foot(p_q, sp_q); wd_tag = 1'b1;
				we_up = 1'b1; wa_up = foot(p_q, sp_q); wd_up = p_q;
			end
			UOP_S1: begin we_size = 1'b1; wa_size = p_q; wd_size = diff; end
			UOP_S2: begin
				we_tag = 1'b1; wa_tag = f_q; wd_tag = 1'b0;
				we_up = 1'b1; wa_up = f_q; wd_up = p_q;
			end
			UOP_S3: begin
				we_size = 1'b1; wa_size = q_q; wd_size = n_q;
				we_tag = 1'b1; wa_tag = q_q; wd_tag = 1'b1;
			end
			UOP_S4: begin
				we_tag = 1'b1; wa_tag = foot(q_q, n_q); wd_tag = 1'b1;
				we_up = 1'b1; wa_up = foot(q_q, n_q); wd_up = q_q;
			end
			UOP_L1: begin we_tag = 1'b1; wa_tag = a_q; wd_tag = 1'b0; end
			UOP_L2: begin
				we_tag = 1'b1; wa_tag = fa; wd_tag = 1'b0;
				we_up = 1'b1; wa_up = fa; wd_up = a_q;
			end
			UOP_L3E: begin
				we_left = 1'b1; wa_left = a_q; wd_left = a_q;
				we_right = 1'b1; wa_right = a_q; wd_right = a_q;
			end
			UOP_L4: begin
				we_left = 1'b1; wa_left = a_q; wd_left = rd_left;
				we_right = 1'b1; wa_right = a_q; wd_right = rover_q;
			end
			UOP_L5: begin we_right = 1'b1; wa_right = q2_q; wd_right = a_q; end
			UOP_L6: begin we_left = 1'b1; wa_left = rover_q; wd_left = a_q; end
			UOP_R1: begin
				we_size = 1'b1; wa_size = pre_q; wd_size = spre_q + sa_q;
				we_tag = 1'b1; wa_tag = fa; wd_tag = 1'b0;
				we_up = 1'b1; wa_up = fa; wd_up = pre_q;
			end
			UOP_M1: begin
				we_tag = 1'b1; wa_tag = a_q; wd_tag = 1'b0;
				we_left = 1'b1; wa_left = a_q; wd_left = sts.m_self ? a_q : ql_q;
				we_right = 1'b1; wa_right = a_q; wd_right = sts.m_self ? a_q : rr_q;
				we_size = 1'b1; wa_size = a_q; wd_size = sa_q + snx_q;
				we_up = 1'b1; wa_up = fn_q; wd_up = a_q;
			end
			UOP_M2: begin we_right = 1'b1; wa_right = ql_q; wd_right = a_q; end
			UOP_M3: begin we_left = 1'b1; wa_left = rr_q; wd_left = a_q; end
			UOP_B1: begin
				we_size = 1'b1; wa_size = pre_q; wd_size = spre_q + sa_q + snx_q;
				we_right = 1'b1; wa_right = ql_q; wd_right = rr_q;
				we_up = 1'b1; wa_up = fn_q; wd_up = pre_q;
			end
			UOP_B2: begin we_left = 1'b1; wa_left = rr_q; wd_left = ql_q; end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_tag) mem_tag[wa_tag] <= wd_tag;
		if (we_size) mem_size[wa_size] <= wd_size;
		if (we_left) mem_left[wa_left] <= wd_left;
		if (we_right) mem_right[wa_right] <= wd_right;
		if (we_up) mem_up[wa_up] <= wd_up;
		rd_tag   <= mem_tag[rd_addr];
		rd_size  <= mem_size[rd_addr];
		rd_left  <= mem_left[rd_addr];
		rd_right <= mem_right[rd_addr];
		rd_up    <= mem_up[rd_addr];
	end

	// Working registers of the current transaction.
	always_ff @(posedge clk) begin
		case (cmd.uop)
			UOP_LOAD: begin
				n_q <= s_tdata[6:0];
				a_q <= s_tdata[12:7];
			end
			UOP_A_START: begin
				p_q <= rover_q;
				res_addr_q <= '0;
				res_size_q <= '0;
			end
			UOP_A_CHK: begin
				if (sts.fit) begin
					sp_q <= rd_size;
					lp_q <= rd_left;
					rp_q <= rd_right;
				end else p_q <= rd_right;
			end
			UOP_W3: begin
				res_addr_q <= p_q;
				res_size_q <= sp_q;
			end
			UOP_S1: f_q <= ix(f7);
			UOP_S2: q_q <= ix(size_t'(f_q) + size_t'(1));
			UOP_S3: begin
				res_addr_q <= q_q;
				res_size_q <= n_q;
			end
			UOP_F_START: begin
				w_q <= '0;
				res_addr_q <= '0;
				res_size_q <= '0;
			end
			UOP_F_WCHK: w_q <= w_q + rd_size;
			UOP_F_TCHK: begin
				sa_q <= rd_size;
				nx_q <= size_t'(a_q) + rd_size;
				lused_q <= 1'b1;
			end
			UOP_F_UCHK: pre_q <= rd_up;
			UOP_F_PCHK: begin
				lused_q <= rd_tag;
				spre_q <= rd_size;
			end
			UOP_F_NRD: rused_q <= 1'b1;
			UOP_F_NCHK: begin
				rused_q <= rd_tag;
				snx_q <= rd_size;
				ql_q <= rd_left;
				rr_q <= rd_right;
				fn_q <= foot(nx_q[AW-1:0], rd_size);
			end
			UOP_L4: q2_q <= rd_left;
			UOP_DONE: begin
				out_st_q <= cmd.code;
				out_addr_q <= res_addr_q;
				out_size_q <= res_size_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			rover_q <= '0;
			empty_q <= 1'b0;
			minrem_q <= 4'd1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) minrem_q <= cfg_data;
			if (cmd.uop == UOP_CLR) clr_q <= clr_q + addr_t'(1);
			case (cmd.uop)
				UOP_A_CHK: if (sts.fit) rover_q <= rd_right;
				UOP_W1:    if (sts.single) empty_q <= 1'b1;
				UOP_L3E: begin
					empty_q <= 1'b0;
					rover_q <= a_q;
				end
				UOP_L6:    rover_q <= a_q;
				UOP_M1, UOP_B1: rover_q <= rover_nx;
				default: ;
			endcase
			if (cmd.uop == UOP_DONE) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		sts.clr_last = (clr_q == addr_t'(MEM_WORDS - 1));
		sts.a_bad    = empty_q || (n_q == '0);
		sts.fit      = (rd_size >= n_q);
		sts.whole    = ((rd_size - n_q) <= size_t'(minrem_q));
		sts.wrap     = (rd_right == rover_q);
		sts.single   = (rp_q == p_q);
		sts.w_ge     = (w_q >= size_t'(a_q));
		sts.w_eq     = (w_q == size_t'(a_q));
		sts.zero_sz  = (rd_size == '0);
		sts.hdr_used = rd_tag;
		sts.a_zero   = (a_q == '0);
		sts.nx_out   = (nx_q >= size_t'(MEM_WORDS));
		sts.lused    = lused_q;
		sts.rused    = rused_q;
		sts.empty    = empty_q;
		sts.m_self   = (size_t'(ql_q) == nx_q);
		sts.out_busy = out_valid_q && !m_tready;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_size_q, out_addr_q};
	assign m_tuser  = out_st_q;

	a_nofit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_st_q == ST_NOFIT |-> out_size_q == '0 && out_addr_q == '0)
		else $error("failed allocate reports a block");
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_st_q == ST_BADFREE |-> out_size_q == '0 && out_addr_q == '0)
		else $error("rejected free reports a block");
	a_load_only: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.uop == UOP_DONE))
		else $error("result register loaded without a finish command");

endmodule

// ===== sv/boundary_tag_allocator_core.sv =====
// Boundary-tag allocator core: a 64-word pool with first-fit allocate and coalescing free.
// Allocate visits free blocks in list order from the rover; free walks block headers from word 0
// up to the freed start. One transaction at a time: a request can be accepted in the same cycle
// as the previous result appears, and a result still waiting in the output register holds
// the next one. Reset is asynchronous and active low; a clearing pass over every pool word
// then builds one free pool-wide block.
module boundary_tag_allocator_core (
	input  logic        clk,
	input  logic        arst_n,
	// Request stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [6:0] alloc_size, [12:7] free_addr, [15:13] zero
	input  logic [0:0]  s_tuser,   // [0] req_type: 0 allocate, 1 free
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [5:0] block_addr, [12:6] block_size, [15:13] zero
	output logic [1:0]  m_tuser,   // [1:0] status
	// Configuration: min_remainder.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data
);
	import bta_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Always writable: the user must write the configuration register only while idle (unchecked).
	assign cfg_ready = 1'b1;

	// The controller sequences each transaction as a string of micro-operations;
	// memory reads are registered, so read data is there in the cycle after its address is issued.
	bta_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.req_type (s_tuser[0]),
		.sts      (sts),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	// The datapath holds the tag, size, link and uplink memories and the result register.
	bta_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

// ===== tb/boundary_tag_allocator_core_test.sv =====
// Self-checking testbench for boundary_tag_allocator_core: allocate and free requests
// are checked against a behavioral pool predictor, across several min_remainder settings.
// Depends on bta_pkg and the core RTL only.
`timescale 1ns / 1ps

module boundary_tag_allocator_core_test;
	import bta_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 200;

	typedef struct packed {
		st_t   status;
		addr_t addr;
		size_t size;
	} grant_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_data;

	boundary_tag_allocator_core DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// Predicted pool: per-word tag, size, free-list links and footer uplink.
	bit          word_used[MEM_WORDS];
	int unsigned word_size[MEM_WORDS];
	int unsigned link_left[MEM_WORDS];
	int unsigned link_right[MEM_WORDS];
	int unsigned uplink[MEM_WORDS];
	int unsigned rover_pos;
	bit          free_list_empty;
	int unsigned absorb_limit;

	grant_t      expected_grants[$];
	addr_t       live_blocks[$];
	bit          quiet_sender;
	bit          quiet_receiver;
	int          rx_hold_cycles;
	int          mismatches;
	int          n_alloc_ok, n_nofit, n_free_ok, n_badfree, n_results;
	int          idle_cycles;

	always #6 clk = ~clk;

	function automatic int unsigned wrap_word(int unsigned a);
		return (a < MEM_WORDS) ? a : 0;
	endfunction

	function automatic int unsigned footer_of(int unsigned p);
		int unsigned s;
		s = word_size[wrap_word(p)];
		return wrap_word(p + ((s != 0) ? s - 1 : 0));
	endfunction

	function automatic void pool_reset();
		for (int i = 0; i < MEM_WORDS; i++) begin
			word_used[i] = 0;
			word_size[i] = 0;
			link_left[i] = 0;
			link_right[i] = 0;
			uplink[i] = 0;
		end
		word_size[0] = MEM_WORDS;
		rover_pos = 0;
		free_list_empty = 0;
		absorb_limit = 1;
	endfunction

	// A start is valid only if walking headers from word 0 lands on it and it is used.
	function automatic bit is_allocated_start(int unsigned a);
		int unsigned p;
		p = 0;
		if (a >= MEM_WORDS)
			return 0;
		while (p < a) begin
			if (word_size[p] == 0)
				return 0;
			p += word_size[p];
		end
		return (p == a) && word_used[a];
	endfunction

	// First fit from the rover; a small leftover is absorbed, otherwise the top is split off.
	function automatic grant_t pool_alloc(int unsigned n);
		grant_t g;
		int unsigned p, nx, f, q;
		g = '{ST_NOFIT, '0, '0};
		if (free_list_empty || n == 0)
			return g;
		p = wrap_word(rover_pos);
		for (int i = 0; i < MEM_WORDS; i++) begin
			if (word_size[p] >= n)
				break;
			p = wrap_word(link_right[p]);
			if (p == wrap_word(rover_pos))
				break;
		end
		if (word_size[p] < n)
			return g;
		nx = wrap_word(link_right[p]);
		rover_pos = nx;
		g.status = ST_OK;
		if (word_size[p] - n <= absorb_limit) begin
			if (nx == p) begin
				free_list_empty = 1;
			end else begin
				link_left[nx] = link_left[p];
				link_right[wrap_word(link_left[p])] = nx;
			end
			f = footer_of(p);
			word_used[p] = 1;
			word_used[f] = 1;
			uplink[f] = p;
			g.addr = addr_t'(p);
			g.size = size_t'(word_size[p]);
		end else begin
			word_size[p] = word_size[p] - n;
			f = footer_of(p);
			word_used[f] = 0;
			uplink[f] = p;
			q = wrap_word(f + 1);
			word_size[q] = n;
			word_used[q] = 1;
			f = footer_of(q);
			word_used[f] = 1;
			uplink[f] = q;
			g.addr = addr_t'(q);
			g.size = size_t'(n);
		end
		return g;
	endfunction

	// Release with coalescing; both pool ends behave as used neighbors.
	function automatic grant_t pool_free(int unsigned a);
		grant_t g;
		int unsigned pre, nx, f, q, r, fn;
		bit lused, rused;
		g = '{ST_BADFREE, '0, '0};
		pre = 0;
		fn = 0;
		if (!is_allocated_start(a))
			return g;
		g.status = ST_OK;
		if (a == 0) begin
			lused = 1;
		end else begin
			pre = wrap_word(uplink[a - 1]);
			lused = word_used[pre];
		end
		nx = a + word_size[a];
		rused = (nx >= MEM_WORDS) ? 1'b1 : word_used[nx];
		if (!rused)
			fn = footer_of(nx);
		if (lused && rused) begin
			word_used[a] = 0;
			f = footer_of(a);
			uplink[f] = a;
			word_used[f] = 0;
			if (free_list_empty) begin
				link_left[a] = a;
				link_right[a] = a;
				free_list_empty = 0;
			end else begin
				q = wrap_word(link_left[wrap_word(rover_pos)]);
				link_right[a] = wrap_word(rover_pos);
				link_left[a] = q;
				link_right[q] = a;
				link_left[wrap_word(rover_pos)] = a;
			end
			rover_pos = a;
		end else if (!lused && rused) begin
			word_size[pre] = word_size[pre] + word_size[a];
			f = footer_of(a);
			uplink[f] = pre;
			word_used[f] = 0;
		end else if (lused && !rused) begin
			word_used[a] = 0;
			q = wrap_word(link_left[nx]);
			r = wrap_word(link_right[nx]);
			if (q == nx) begin
				link_left[a] = a;
				link_right[a] = a;
			end else begin
				link_left[a] = q;
				link_right[q] = a;
				link_right[a] = r;
				link_left[r] = a;
			end
			word_size[a] = word_size[a] + word_size[nx];
			uplink[fn] = a;
			if (wrap_word(rover_pos) == nx)
				rover_pos = a;
		end else begin
			word_size[pre] = word_size[pre] + word_size[a] + word_size[nx];
			q = wrap_word(link_left[nx]);
			r = wrap_word(link_right[nx]);
			link_right[q] = r;
			link_left[r] = q;
			uplink[fn] = pre;
			if (wrap_word(rover_pos) == nx)
				rover_pos = pre;
		end
		return g;
	endfunction

	// Offers one request, waits for the transaction and records the predicted grant.
	task automatic send_request(bit is_free, logic [6:0] n, logic [5:0] a);
		int gap;
		grant_t g;
		gap = quiet_sender ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, a, n};
		s_tuser <= is_free;
		do @(posedge clk); while (!s_tready);
		if (is_free) begin
			g = pool_free(a);
			if (g.status == ST_OK) begin
				n_free_ok++;
				foreach (live_blocks[i])
					if (live_blocks[i] == a) begin
						live_blocks.delete(i);
						break;
					end
			end else begin
				n_badfree++;
			end
		end else begin
			g = pool_alloc(n);
			if (g.status == ST_OK) begin
				n_alloc_ok++;
				live_blocks.push_back(g.addr);
			end else begin
				n_nofit++;
			end
		end
		expected_grants.push_back(g);
	endtask

	task automatic alloc_req(int unsigned n);
		send_request(1'b0, n[6:0], 6'($urandom));
	endtask

	task automatic free_req(int unsigned a);
		send_request(1'b1, 7'($urandom), a[5:0]);
	endtask

	// Lets every outstanding result drain, plus the core's worst latency.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_grants.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_min_remainder(logic [3:0] v);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		absorb_limit = v;
	endtask

	// Extremes of the pool: whole-pool grant, empty list, zero and oversized requests,
	// bad frees, and frees that hit every neighbor-merge case but the one with both neighbors free.
	task automatic test_directed();
		alloc_req(64);
		alloc_req(1);
		free_req(63);
		free_req(0);
		alloc_req(0);
		alloc_req(65);
		alloc_req(127);
		alloc_req(10);
		alloc_req(10);
		alloc_req(10);
		alloc_req(10);
		alloc_req(23);
		free_req(45);
		free_req(44);
		free_req(34);
		free_req(54);
		free_req(24);
		free_req(0);
		alloc_req(64);
		free_req(0);
		free_req(0);
	endtask

	// Random traffic: mostly small allocations and frees of live blocks, some noise.
	task automatic test_random(int count);
		int unsigned pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 48) begin
				alloc_req($urandom_range(1, 12));
			end else if (pick < 54) begin
				alloc_req($urandom_range(0, 127));
			end else if (pick < 90 && live_blocks.size() != 0) begin
				free_req(live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
			end else begin
				free_req($urandom_range(0, 63));
			end
		end
	endtask

	// The receiver stops for a long stretch while requests keep coming.
	task automatic test_backpressure();
		rx_hold_cycles = 400;
		quiet_sender = 1;
		test_random(20);
		quiet_sender = 0;
	endtask

	// Result sink with random stalls and an optional long hold-off.
	initial begin
		int n;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_hold_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (rx_hold_cycles) @(posedge clk);
				rx_hold_cycles = 0;
			end
			n = quiet_receiver ? 0 : $urandom_range(0, 12);
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Result checker: each transaction against the oldest prediction.
	always @(posedge clk) begin
		grant_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = st_t'(m_tuser);
			got.addr = m_tdata[5:0];
			got.size = m_tdata[12:6];
			n_results++;
			if (expected_grants.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d addr %0d size %0d",
						got.status, got.addr, got.size);
			end else begin
				want = expected_grants.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: expected st %0d addr %0d size %0d, got st %0d addr %0d size %0d",
							n_results, want.status, want.addr, want.size,
							got.status, got.addr, got.size);
				end
			end
		end
	end

	// Watchdog on cycles with no transaction on any channel.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", expected_grants.size());
			$display("boundary_tag_allocator_core_test: FAIL");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		quiet_sender = 0;
		quiet_receiver = 0;
		rx_hold_cycles = 0;
		mismatches = 0;
		n_results = 0;
		idle_cycles = 0;
		n_alloc_ok = 0;
		n_nofit = 0;
		n_free_ok = 0;
		n_badfree = 0;
		pool_reset();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(90);
		write_min_remainder(4'd0);
		test_random(90);
		write_min_remainder(4'd15);
		test_random(90);
		test_backpressure();
		write_min_remainder(4'd8);
		quiet_sender = 1;
		quiet_receiver = 1;
		test_random(80);
		quiet_sender = 0;
		quiet_receiver = 0;
		write_min_remainder(4'($urandom_range(2, 7)));
		test_random(80);
		write_min_remainder(4'd1);
		test_random(80);
		wait_idle();

		$display("covered %0d grants, %0d no-fit, %0d frees, %0d rejected frees",
			n_alloc_ok, n_nofit, n_free_ok, n_badfree);
		$display("min_remainder settings 1, 0, 15, 8 and a random one; %0d mismatches",
			mismatches);
		if (mismatches == 0 && expected_grants.size() == 0)
			$display("boundary_tag_allocator_core_test: PASS");
		else
			$display("boundary_tag_allocator_core_test: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
sv/bta_pkg.sv
sv/bta_ctrl.sv
sv/bta_dp.sv
sv/boundary_tag_allocator_core.sv
tb/boundary_tag_allocator_core_test.sv
